// File: rtl/assert_macros.svh
// assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/orb_pkg.sv
package orb_pkg;

    // built store geometry
    localparam int DEPTH  = 16;
    localparam int WIDTH  = 32;
    localparam int DATA_W = 32;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WRAP_W = CNT_W + 1;

    // largest run of results from one read-last-n
    localparam logic [CNT_W-1:0] MAX_RUN   = CNT_W'(16);
    localparam logic [CNT_W-1:0] FILL_MAX  = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(16);

    // configuration register map
    localparam int PADDR_W = 3;
    localparam logic REG_CAPACITY = 1'b0;

    // input mode codes
    localparam logic [2:0] MODE_INSERT    = 3'd0;
    localparam logic [2:0] MODE_DEQUEUE   = 3'd1;
    localparam logic [2:0] MODE_PEEK_NEW  = 3'd2;
    localparam logic [2:0] MODE_PEEK_OLD  = 3'd3;
    localparam logic [2:0] MODE_READ_LAST = 3'd4;

    // classified operation
    typedef enum logic [2:0] {
        OP_INSERT,
        OP_DEQUEUE,
        OP_PEEK_NEW,
        OP_PEEK_OLD,
        OP_READ_LAST,
        OP_BAD
    } op_t;

    // command passed from the front end to the back end
    typedef struct packed {
        op_t              op;
        logic [WIDTH-1:0] data;
        logic [CNT_W-1:0] req;
    } cmd_t;

endpackage

// File: rtl/orb_ram.sv
module orb_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // one write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/orb_front.sv
module orb_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [2:0]                 mode,
    input  logic [orb_pkg::DATA_W-1:0] item_data,
    input  logic [orb_pkg::CNT_W-1:0]  request_count,
    output logic                       cmd_valid,
    output orb_pkg::cmd_t              cmd,
    input  logic                       cmd_pop
);

    orb_pkg::cmd_t q_mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic [1:0]    count_next;
    orb_pkg::cmd_t new_cmd;
    logic          push;

    // classify the incoming transfer
    always_comb
    begin
        new_cmd.data = item_data[orb_pkg::WIDTH-1:0];
        new_cmd.req  = (request_count > orb_pkg::MAX_RUN) ? orb_pkg::MAX_RUN : request_count;
        unique case (mode)
            orb_pkg::MODE_INSERT:    new_cmd.op = orb_pkg::OP_INSERT;
            orb_pkg::MODE_DEQUEUE:   new_cmd.op = orb_pkg::OP_DEQUEUE;
            orb_pkg::MODE_PEEK_NEW:  new_cmd.op = orb_pkg::OP_PEEK_NEW;
            orb_pkg::MODE_PEEK_OLD:  new_cmd.op = orb_pkg::OP_PEEK_OLD;
            orb_pkg::MODE_READ_LAST: new_cmd.op = orb_pkg::OP_READ_LAST;
            default:                 new_cmd.op = orb_pkg::OP_BAD;
        endcase
    end

    // two-entry command queue
    assign in_stall  = (count_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

// File: rtl/orb_back.sv
module orb_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       clear,
    input  logic [orb_pkg::CNT_W-1:0]  cap,
    input  logic                       cmd_valid,
    input  orb_pkg::cmd_t              cmd,
    output logic                       cmd_pop,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [orb_pkg::DATA_W-1:0] out_data,
    output logic                       status,
    output logic [orb_pkg::CNT_W-1:0]  fill_level,
    output logic                       last_of_run
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_OUT  = 3'b100
    } state_t;

    state_t                      state_reg, state_next;
    logic [orb_pkg::IDX_W-1:0]   wr_idx_reg, wr_idx_next;
    logic [orb_pkg::CNT_W-1:0]   fill_reg, fill_next;
    logic [orb_pkg::CNT_W-1:0]   remain_reg, remain_next;
    logic [orb_pkg::IDX_W-1:0]   addr_reg, addr_next;
    logic [orb_pkg::DATA_W-1:0]  out_data_reg;
    logic                        status_reg;
    logic [orb_pkg::CNT_W-1:0]   fill_level_reg;
    logic                        last_reg;

    logic [orb_pkg::WRAP_W-1:0]  cap_w;
    logic [orb_pkg::WRAP_W-1:0]  oldest_sum;
    logic [orb_pkg::IDX_W-1:0]   oldest;
    logic [orb_pkg::CNT_W-1:0]   run_n;
    logic [orb_pkg::WRAP_W-1:0]  start_sum;
    logic [orb_pkg::IDX_W-1:0]   start;
    logic [orb_pkg::IDX_W-1:0]   newest;
    logic [orb_pkg::IDX_W-1:0]   wr_inc;
    logic [orb_pkg::IDX_W-1:0]   addr_inc;
    logic [orb_pkg::IDX_W-1:0]   rd_addr;
    logic [orb_pkg::WIDTH-1:0]   rd_data;
    logic                        ram_we;
    logic                        load_imm;
    logic                        imm_status;
    logic                        load_rd;

    // slot store
    orb_ram #(
        .DATA_W (orb_pkg::WIDTH),
        .DEPTH  (orb_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (cmd.data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // slot arithmetic, every sum stays below twice the capacity
    assign cap_w      = {1'b0, cap};
    assign oldest_sum = {2'b00, wr_idx_reg} + cap_w - {1'b0, fill_reg};
    assign oldest     = (oldest_sum >= cap_w) ? orb_pkg::IDX_W'(oldest_sum - cap_w)
                                              : orb_pkg::IDX_W'(oldest_sum);
    assign run_n      = (cmd.req > fill_reg) ? fill_reg : cmd.req;
    assign start_sum  = {2'b00, oldest} + {1'b0, fill_reg - run_n};
    assign start      = (start_sum >= cap_w) ? orb_pkg::IDX_W'(start_sum - cap_w)
                                             : orb_pkg::IDX_W'(start_sum);
    assign newest     = (wr_idx_reg == '0) ? orb_pkg::IDX_W'(cap - 1'b1)
                                           : wr_idx_reg - 1'b1;
    assign wr_inc     = ({1'b0, wr_idx_reg} + 1'b1 == cap) ? '0 : wr_idx_reg + 1'b1;
    assign addr_inc   = ({1'b0, addr_reg} + 1'b1 == cap) ? '0 : addr_reg + 1'b1;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        wr_idx_next = wr_idx_reg;
        fill_next   = fill_reg;
        remain_next = remain_reg;
        addr_next   = addr_reg;
        rd_addr     = addr_reg;
        ram_we      = 1'b0;
        cmd_pop     = 1'b0;
        load_imm    = 1'b0;
        imm_status  = 1'b1;
        load_rd     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop     = 1'b1;
                    remain_next = orb_pkg::CNT_W'(1);
                    unique case (cmd.op) inside
                        orb_pkg::OP_INSERT:
                        begin
                            ram_we      = 1'b1;
                            wr_idx_next = wr_inc;
                            if (fill_reg < cap)
                            begin
                                fill_next = fill_reg + 1'b1;
                            end
                            load_imm   = 1'b1;
                            imm_status = 1'b0;
                            state_next = S_OUT;
                        end
                        orb_pkg::OP_DEQUEUE, orb_pkg::OP_PEEK_OLD:
                        begin
                            if (fill_reg == '0)
                            begin
                                load_imm   = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                rd_addr    = oldest;
                                addr_next  = oldest;
                                state_next = S_READ;
                                if (cmd.op == orb_pkg::OP_DEQUEUE)
                                begin
                                    fill_next = fill_reg - 1'b1;
                                end
                            end
                        end
                        orb_pkg::OP_PEEK_NEW:
                        begin
                            if (fill_reg == '0)
                            begin
                                load_imm   = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                rd_addr    = newest;
                                addr_next  = newest;
                                state_next = S_READ;
                            end
                        end
                        orb_pkg::OP_READ_LAST:
                        begin
                            if (run_n == '0)
                            begin
                                load_imm   = 1'b1;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                rd_addr     = start;
                                addr_next   = start;
                                remain_next = run_n;
                                state_next  = S_READ;
                            end
                        end
                        default:
                        begin
                            load_imm   = 1'b1;
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                load_rd    = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (remain_reg > orb_pkg::CNT_W'(1))
                    begin
                        remain_next = remain_reg - 1'b1;
                        addr_next   = addr_inc;
                        rd_addr     = addr_inc;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wr_idx_reg <= '0;
            fill_reg   <= '0;
            remain_reg <= '0;
            addr_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
            addr_reg   <= addr_next;
            if (clear)
            begin
                wr_idx_reg <= '0;
                fill_reg   <= '0;
            end
            else
            begin
                wr_idx_reg <= wr_idx_next;
                fill_reg   <= fill_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (load_imm)
        begin
            out_data_reg   <= '0;
            status_reg     <= imm_status;
            fill_level_reg <= fill_next;
            last_reg       <= 1'b1;
        end
        else if (load_rd)
        begin
            out_data_reg   <= orb_pkg::DATA_W'(rd_data);
            status_reg     <= 1'b0;
            fill_level_reg <= fill_reg;
            last_reg       <= (remain_reg == orb_pkg::CNT_W'(1));
        end
    end

    assign out_valid   = (state_reg == S_OUT);
    assign out_data    = out_data_reg;
    assign status      = status_reg;
    assign fill_level  = fill_level_reg;
    assign last_of_run = last_reg;

endmodule

// File: rtl/overwriting_ring_buffer_unit.sv
// Overwriting ring buffer of 32-bit entries over a 16-slot store, of which the
// capacity register (byte address 0, reset 16, 0 acts as 1, above 16 acts as 16)
// selects how many slots are used; writing it also empties the buffer. Modes:
// insert (overwrites the oldest entry when full), dequeue oldest, peek newest,
// peek oldest, and read last n, which returns up to n newest entries oldest
// first with last_of_run on the final one. Requests that find nothing give one
// result with status 1 and zero data. Items enter a two-entry command queue, so
// the input keeps taking transfers while a result waits, until both entries are
// filled. The back end sequencer takes a new command only when idle, once the
// last result of the current one has left. An insert, an unused mode or a request
// that finds nothing goes straight to the output state; each entry read passes
// the store's registered read port in a read state first. A stalled output holds.
module overwriting_ring_buffer_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [2:0]                   mode,
    input  logic [orb_pkg::DATA_W-1:0]   item_data,
    input  logic [orb_pkg::CNT_W-1:0]    request_count,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [orb_pkg::DATA_W-1:0]   out_data,
    output logic                         status,
    output logic [orb_pkg::CNT_W-1:0]    fill_level,
    output logic                         last_of_run,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [orb_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    logic [orb_pkg::CNT_W-1:0] capacity_reg;
    logic [orb_pkg::CNT_W-1:0] eff_cap;
    logic                      cap_write;
    logic                      reg_sel;
    logic                      cmd_valid;
    orb_pkg::cmd_t             cmd;
    logic                      cmd_pop;

    // configuration port
    assign pready    = 1'b1;
    assign reg_sel   = paddr[2];
    assign cap_write = psel && penable && pwrite && pready && (reg_sel == orb_pkg::REG_CAPACITY);
    assign prdata    = (reg_sel == orb_pkg::REG_CAPACITY) ? 32'(capacity_reg) : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= orb_pkg::CAP_RESET;
        end
        else if (cap_write)
        begin
            capacity_reg <= pwdata[orb_pkg::CNT_W-1:0];
        end
    end

    // clamp capacity into the built range
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = orb_pkg::CNT_W'(1);
        end
        else if (capacity_reg > orb_pkg::FILL_MAX)
        begin
            eff_cap = orb_pkg::FILL_MAX;
        end
        else
        begin
            eff_cap = capacity_reg;
        end
    end

    orb_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .item_data     (item_data),
        .request_count (request_count),
        .cmd_valid     (cmd_valid),
        .cmd           (cmd),
        .cmd_pop       (cmd_pop)
    );

    orb_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .clear       (cap_write),
        .cap         (eff_cap),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .status      (status),
        .fill_level  (fill_level),
        .last_of_run (last_of_run)
    );

endmodule

// File: rtl/orb_checker.sv
`include "assert_macros.svh"

module orb_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_stall,
    input logic [orb_pkg::DATA_W-1:0] out_data,
    input logic                       status,
    input logic [orb_pkg::CNT_W-1:0]  fill_level,
    input logic                       last_of_run
);

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data) && $stable(last_of_run))

    // an empty answer carries zero data and ends its run
    `ASSERT_SAME(a_empty_result, clk, rst_n, out_valid && status, out_data == '0 && last_of_run)

    // fill level never exceeds the built depth
    `ASSERT_SAME(a_fill_range, clk, rst_n, out_valid, fill_level <= orb_pkg::FILL_MAX)

    // a result inside a run reads a held entry
    `ASSERT_SAME(a_run_ok, clk, rst_n, out_valid && !last_of_run, !status && fill_level != '0)

endmodule

bind overwriting_ring_buffer_unit orb_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .status      (status),
    .fill_level  (fill_level),
    .last_of_run (last_of_run)
);
